// File: rtl/bmp565_pkg.sv
// Shared constants, types and command format for the BMP to RGB565 stream unit.
`default_nettype none

package bmp565_pkg;

  // Largest usable canvas side; larger register values are clamped to it.
  localparam int MAX_CANVAS_SIDE = 2048;
  localparam int SIDE_W          = $clog2(MAX_CANVAS_SIDE + 1);
  localparam int COORD_W         = $clog2(MAX_CANVAS_SIDE);

  localparam int CFG_W    = 12;
  localparam int ADDR_W   = 22;
  localparam int COLOR_W  = 16;
  localparam int STATUS_W = 2;

  localparam int FIFO_DEPTH = 4;

  // File header layout.
  localparam int HDR_LEN  = 54;
  localparam int POS_SIG0 = 0;
  localparam int POS_SIG1 = 1;
  localparam int POS_OFF0 = 10;
  localparam int POS_W0   = 18;
  localparam int POS_H0   = 22;
  localparam int POS_BPP0 = 28;

  localparam logic [7:0]  CHAR_B   = 8'h42;
  localparam logic [7:0]  CHAR_M   = 8'h4D;
  localparam logic [15:0] DEPTH_24 = 16'd24;
  localparam logic [15:0] DEPTH_32 = 16'd32;

  typedef enum logic [STATUS_W-1:0] {
    ST_PIXEL    = 2'd0,
    ST_DONE     = 2'd1,
    ST_BADSIG   = 2'd2,
    ST_BADDEPTH = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    PH_HEADER   = 2'd0,
    PH_SKIP     = 2'd1,
    PH_PIXELS   = 2'd2,
    PH_FINISHED = 2'd3
  } phase_t;

  typedef enum logic {
    CFG_CANVAS_WIDTH  = 1'b0,
    CFG_CANVAS_HEIGHT = 1'b1
  } cfg_idx_t;

  // One queued request from the parser to the write-out pipeline.
  typedef struct packed {
    status_t              status;
    logic [COORD_W-1:0]   row;
    logic [COORD_W-1:0]   col;
    logic [COLOR_W-1:0]   color;
  } cmd_t;

endpackage

`default_nettype wire

// File: rtl/bmp565_ifs.sv
// Valid/ready channel interfaces for the byte input and the pixel output.
`default_nettype none

interface bmp565_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first_byte;

  modport source (output valid, data_byte, first_byte, input ready);
  modport sink   (input valid, data_byte, first_byte, output ready);
endinterface

interface bmp565_out_if;
  import bmp565_pkg::*;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [ADDR_W-1:0]   pixel_address;
  logic [COLOR_W-1:0]  pixel_color;

  modport source (output valid, status, pixel_address, pixel_color, input ready);
  modport sink   (input valid, status, pixel_address, pixel_color, output ready);
endinterface

`default_nettype wire

// File: rtl/bmp565_front.sv
// Byte parser: header capture, offset skip, row walk and clipping decisions.
`default_nettype none

module bmp565_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [7:0]                   data_byte,
  input  logic                         first_byte,
  input  logic [bmp565_pkg::SIDE_W-1:0] canvas_w,
  input  logic [bmp565_pkg::SIDE_W-1:0] canvas_h,
  input  logic                         q_full,
  output logic                         push,
  output bmp565_pkg::cmd_t             cmd
);
  import bmp565_pkg::*;

  localparam int PAD_W = 32 - SIDE_W;

  phase_t             phase, phase_next;
  logic [31:0]        byte_pos, byte_pos_next;
  logic [31:0]        img_w, img_w_next;
  logic [31:0]        img_h, img_h_next;
  logic [15:0]        bpp_bits, bpp_bits_next;
  logic [31:0]        data_off, data_off_next;
  logic               bottom_up, bottom_up_next;
  logic               sig_good, sig_good_next;
  logic               done_pend, done_pend_next;
  logic [31:0]        rows_left, rows_left_next;
  logic [31:0]        dy, dy_next;
  logic [33:0]        byte_in_row, byte_in_row_next;
  logic [1:0]         pix_k, pix_k_next;
  logic [SIDE_W-1:0]  pix_x, pix_x_next;
  logic [7:0]         held_blue, held_blue_next;
  logic [7:0]         held_green, held_green_next;
  logic [33:0]        row_stride;

  // State as seen by this byte, after a possible restart.
  phase_t      e_phase;
  logic [31:0] e_pos, e_w, e_h, e_off;
  logic [15:0] e_bpp;
  logic        e_bu, e_sig, e_pend;

  logic        accept, pend_fire, in_hdr, hdr_last, h_neg, depth_ok, need_skip;
  logic        skip_last, enter, bu_now, empty_img, in_px, vis, row_end, last_row;
  logic [31:0] h_mag, h_now;
  logic [1:0]  k_max;
  logic        emit;
  status_t     emit_status;
  logic [33:0] w_ext, w_bytes;

  // Row stride follows the captured width and depth; both settle long before
  // the pixel data starts.
  always_comb begin
    w_ext   = {2'b00, img_w};
    w_bytes = (bpp_bits == DEPTH_32) ? (w_ext << 2) : ((w_ext << 1) + w_ext);
  end

  always_ff @(posedge clk) begin
    row_stride <= (w_bytes + 34'd3) & ~34'd3;
  end

  always_comb begin
    e_phase = phase;
    e_pos   = byte_pos;
    e_w     = img_w;
    e_h     = img_h;
    e_bpp   = bpp_bits;
    e_off   = data_off;
    e_bu    = bottom_up;
    e_sig   = sig_good;
    e_pend  = done_pend;
    if (first_byte) begin
      e_phase = PH_HEADER;
      e_pos   = '0;
      e_w     = '0;
      e_h     = '0;
      e_bpp   = '0;
      e_off   = '0;
      e_bu    = 1'b1;
      e_sig   = 1'b0;
      e_pend  = 1'b0;
    end
  end

  // Decisions shared by the next-state and output logic.
  always_comb begin
    accept    = in_valid && in_ready;
    pend_fire = e_pend;
    in_hdr    = !e_pend && (e_phase == PH_HEADER);
    hdr_last  = in_hdr && (e_pos == 32'(HDR_LEN - 1));
    h_neg     = e_h[31];
    h_mag     = h_neg ? (32'd0 - e_h) : e_h;
    depth_ok  = (e_bpp == DEPTH_24) || (e_bpp == DEPTH_32);
    need_skip = e_off > 32'(HDR_LEN);
    skip_last = !e_pend && (e_phase == PH_SKIP) &&
                (({1'b0, e_pos} + 33'd1) >= {1'b0, e_off});
    enter     = (hdr_last && e_sig && depth_ok && !need_skip) || skip_last;
    h_now     = hdr_last ? h_mag : e_h;
    bu_now    = hdr_last ? (e_bu && !h_neg) : e_bu;
    empty_img = e_w[31] || (e_w == 32'd0) || (h_now == 32'd0);
    in_px     = !e_pend && (e_phase == PH_PIXELS);
    k_max     = (e_bpp == DEPTH_32) ? 2'd3 : 2'd2;
    vis       = in_px && (pix_k == 2'd2) && (pix_x < canvas_w) &&
                ({{PAD_W{1'b0}}, pix_x} < e_w) && (dy < {{PAD_W{1'b0}}, canvas_h});
    row_end   = in_px && ((byte_in_row + 34'd1) == row_stride);
    last_row  = row_end && (rows_left == 32'd1);
  end

  // Next state.
  always_comb begin
    phase_next       = phase;
    byte_pos_next    = byte_pos;
    img_w_next       = img_w;
    img_h_next       = img_h;
    bpp_bits_next    = bpp_bits;
    data_off_next    = data_off;
    bottom_up_next   = bottom_up;
    sig_good_next    = sig_good;
    done_pend_next   = done_pend;
    rows_left_next   = rows_left;
    dy_next          = dy;
    byte_in_row_next = byte_in_row;
    pix_k_next       = pix_k;
    pix_x_next       = pix_x;
    held_blue_next   = held_blue;
    held_green_next  = held_green;
    if (accept) begin
      phase_next     = e_phase;
      byte_pos_next  = e_pos;
      img_w_next     = e_w;
      img_h_next     = e_h;
      bpp_bits_next  = e_bpp;
      data_off_next  = e_off;
      bottom_up_next = e_bu;
      sig_good_next  = e_sig;
      done_pend_next = e_pend;
      if (pend_fire) begin
        done_pend_next = 1'b0;
      end else begin
        case (e_phase)
          PH_HEADER: begin
            byte_pos_next = e_pos + 32'd1;
            case (e_pos[5:0])
              6'(POS_SIG0):     sig_good_next = (data_byte == CHAR_B);
              6'(POS_SIG1):     sig_good_next = e_sig && (data_byte == CHAR_M);
              6'(POS_OFF0):     data_off_next[7:0]   = data_byte;
              6'(POS_OFF0 + 1): data_off_next[15:8]  = data_byte;
              6'(POS_OFF0 + 2): data_off_next[23:16] = data_byte;
              6'(POS_OFF0 + 3): data_off_next[31:24] = data_byte;
              6'(POS_W0):       img_w_next[7:0]      = data_byte;
              6'(POS_W0 + 1):   img_w_next[15:8]     = data_byte;
              6'(POS_W0 + 2):   img_w_next[23:16]    = data_byte;
              6'(POS_W0 + 3):   img_w_next[31:24]    = data_byte;
              6'(POS_H0):       img_h_next[7:0]      = data_byte;
              6'(POS_H0 + 1):   img_h_next[15:8]     = data_byte;
              6'(POS_H0 + 2):   img_h_next[23:16]    = data_byte;
              6'(POS_H0 + 3):   img_h_next[31:24]    = data_byte;
              6'(POS_BPP0):     bpp_bits_next[7:0]   = data_byte;
              6'(POS_BPP0 + 1): bpp_bits_next[15:8]  = data_byte;
              default: ;
            endcase
            if (hdr_last) begin
              if (!e_sig) begin
                phase_next = PH_FINISHED;
              end else begin
                img_h_next     = h_mag;
                bottom_up_next = bu_now;
                if (!depth_ok) begin
                  phase_next = PH_FINISHED;
                end else if (need_skip) begin
                  phase_next = PH_SKIP;
                end
              end
            end
          end
          PH_SKIP: begin
            byte_pos_next = e_pos + 32'd1;
          end
          PH_PIXELS: begin
            case (pix_k)
              2'd0:    held_blue_next  = data_byte;
              2'd1:    held_green_next = data_byte;
              default: ;
            endcase
            byte_in_row_next = byte_in_row + 34'd1;
            if (pix_k == k_max) begin
              pix_k_next = 2'd0;
              if (pix_x != SIDE_W'(MAX_CANVAS_SIDE)) begin
                pix_x_next = pix_x + SIDE_W'(1);
              end
            end else begin
              pix_k_next = pix_k + 2'd1;
            end
            if (row_end) begin
              byte_in_row_next = '0;
              pix_k_next       = 2'd0;
              pix_x_next       = '0;
              rows_left_next   = rows_left - 32'd1;
              dy_next          = bottom_up ? (dy - 32'd1) : (dy + 32'd1);
              if (last_row) begin
                phase_next     = PH_FINISHED;
                done_pend_next = vis;
              end
            end
          end
          default: ;
        endcase
      end
      if (enter) begin
        phase_next       = empty_img ? PH_FINISHED : PH_PIXELS;
        byte_in_row_next = '0;
        pix_k_next       = 2'd0;
        pix_x_next       = '0;
        rows_left_next   = h_now;
        dy_next          = bu_now ? (h_now - 32'd1) : 32'd0;
      end
    end
  end

  // Outputs.
  always_comb begin
    emit        = 1'b1;
    emit_status = ST_DONE;
    if (pend_fire) begin
      emit_status = ST_DONE;
    end else if (hdr_last && !e_sig) begin
      emit_status = ST_BADSIG;
    end else if (hdr_last && !depth_ok) begin
      emit_status = ST_BADDEPTH;
    end else if (enter && empty_img) begin
      emit_status = ST_DONE;
    end else if (vis) begin
      emit_status = ST_PIXEL;
    end else if (last_row) begin
      emit_status = ST_DONE;
    end else begin
      emit = 1'b0;
    end
    in_ready   = !q_full;
    push       = accept && emit;
    cmd.status = emit_status;
    cmd.row    = (emit_status == ST_PIXEL) ? dy[COORD_W-1:0] : '0;
    cmd.col    = (emit_status == ST_PIXEL) ? pix_x[COORD_W-1:0] : '0;
    cmd.color  = (emit_status == ST_PIXEL) ?
                 {data_byte[7:3], held_green[7:2], held_blue[7:3]} : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_HEADER;
      byte_pos    <= '0;
      img_w       <= '0;
      img_h       <= '0;
      bpp_bits    <= '0;
      data_off    <= '0;
      bottom_up   <= 1'b1;
      sig_good    <= 1'b0;
      done_pend   <= 1'b0;
      rows_left   <= '0;
      dy          <= '0;
      byte_in_row <= '0;
      pix_k       <= '0;
      pix_x       <= '0;
    end else begin
      phase       <= phase_next;
      byte_pos    <= byte_pos_next;
      img_w       <= img_w_next;
      img_h       <= img_h_next;
      bpp_bits    <= bpp_bits_next;
      data_off    <= data_off_next;
      bottom_up   <= bottom_up_next;
      sig_good    <= sig_good_next;
      done_pend   <= done_pend_next;
      rows_left   <= rows_left_next;
      dy          <= dy_next;
      byte_in_row <= byte_in_row_next;
      pix_k       <= pix_k_next;
      pix_x       <= pix_x_next;
    end
  end

  always_ff @(posedge clk) begin
    held_blue  <= held_blue_next;
    held_green <= held_green_next;
  end

  // A deferred done only exists once the image has finished.
  a_pend_finished: assert property (@(posedge clk) disable iff (rst)
    done_pend |-> (phase == PH_FINISHED))
    else $error("deferred done outside finished phase");

  // The pixel phase always has at least one row left to walk.
  a_rows_left: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_PIXELS) |-> (rows_left != 32'd0))
    else $error("pixel phase with no rows left");

  // The byte lane index stays below the pixel size.
  a_lane_range: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_PIXELS) |-> ((pix_k != 2'd3) || (bpp_bits == DEPTH_32)))
    else $error("byte lane beyond 24-bit pixel");

  // Requests are only queued for accepted bytes.
  a_push_accept: assert property (@(posedge clk) disable iff (rst)
    push |-> (in_valid && in_ready))
    else $error("request queued without an accepted byte");

endmodule

`default_nettype wire

// File: rtl/bmp565_fifo.sv
// Short request queue between the parser and the write-out pipeline.
`default_nettype none

module bmp565_fifo (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  bmp565_pkg::cmd_t push_data,
  output logic             full,
  input  logic             pop,
  output bmp565_pkg::cmd_t pop_data,
  output logic             not_empty
);
  import bmp565_pkg::*;

  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

  cmd_t             slots [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count, count_next;

  assign full      = (count == CNT_W'(FIFO_DEPTH));
  assign not_empty = (count != '0);
  assign pop_data  = slots[rd_ptr];

  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + CNT_W'(1);
    end else if (pop && !push) begin
      count_next = count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("push into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> not_empty)
    else $error("pop from an empty queue");

  a_count_up: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + CNT_W'(1)))
    else $error("queue count missed a push");

endmodule

`default_nettype wire

// File: rtl/bmp565_back.sv
// Write-out pipeline: row times pitch multiply, column add and output register.
`default_nettype none

module bmp565_back (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             q_valid,
  output logic                             q_pop,
  input  bmp565_pkg::cmd_t                 q_data,
  input  logic [bmp565_pkg::SIDE_W-1:0]    canvas_w,
  output logic                             out_valid,
  input  logic                             out_ready,
  output bmp565_pkg::status_t              status,
  output logic [bmp565_pkg::ADDR_W-1:0]    pixel_address,
  output logic [bmp565_pkg::COLOR_W-1:0]   pixel_color
);
  import bmp565_pkg::*;

  localparam int PROD_W = COORD_W + SIDE_W;

  logic                a_valid;
  status_t             a_status;
  logic [ADDR_W-1:0]   a_prod;
  logic [COORD_W-1:0]  a_col;
  logic [COLOR_W-1:0]  a_color;
  logic [PROD_W-1:0]   prod;
  logic                a_ready, b_ready;

  assign b_ready = !out_valid || out_ready;
  assign a_ready = !a_valid || b_ready;
  assign q_pop   = q_valid && a_ready;
  assign prod    = q_data.row * canvas_w;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (a_ready) begin
        a_valid <= q_valid;
      end
      if (b_ready) begin
        out_valid <= a_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      a_status <= q_data.status;
      a_prod   <= prod[ADDR_W-1:0];
      a_col    <= q_data.col;
      a_color  <= q_data.color;
    end
    if (b_ready && a_valid) begin
      status        <= a_status;
      pixel_address <= a_prod + {{(ADDR_W - COORD_W){1'b0}}, a_col};
      pixel_color   <= a_color;
    end
  end

  a_status_only: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status != ST_PIXEL)) |-> ((pixel_address == '0) && (pixel_color == '0)))
    else $error("status result carries pixel data");

  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
    (a_valid && !b_ready) |=> a_valid)
    else $error("middle stage dropped a request");

  a_pop_valid: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("pop without a queued request");

endmodule

`default_nettype wire

// File: rtl/bmp_to_rgb565_stream_unit.sv
// Top level of the BMP (24/32 bit) to RGB565 pixel write stream unit.
//
//   Channel  Dir  Handshake      Payload
//   -------  ---  -------------  -------------------------------------------
//   in_ch    in   valid / ready  data_byte[7:0], first_byte
//   out_ch   out  valid / ready  status[1:0], pixel_address[21:0],
//                                pixel_color[15:0]
//   cfg      in   cfg_we         cfg_index (0 width, 1 height), cfg_data[11:0]
//
// One file byte is taken per clock while the request queue is not full; each
// byte yields at most one request. The parser decides at the input edge and
// writes the request into the four-entry queue; the row-times-pitch multiply
// and the column add are then each registered on the way out.
// Reset is synchronous on rst and clears all control state; the canvas size
// registers return to 640 by 480. The input stalls only when the request
// queue is full, which happens when the output side holds off for a while.
`default_nettype none

module bmp_to_rgb565_stream_unit (
  input  logic                        clk,
  input  logic                        rst,
  bmp565_in_if.sink                   in_ch,
  bmp565_out_if.source                out_ch,
  input  logic                        cfg_we,
  input  bmp565_pkg::cfg_idx_t        cfg_index,
  input  logic [bmp565_pkg::CFG_W-1:0] cfg_data
);
  import bmp565_pkg::*;

  logic [CFG_W-1:0]  canvas_width, canvas_height;
  logic [SIDE_W-1:0] cw_eff, ch_eff;

  logic    push, q_full, q_pop, q_valid;
  cmd_t    push_cmd, pop_cmd;
  status_t out_status;

  // Configuration registers must be written only while idle (not enforced).
  always_ff @(posedge clk) begin
    if (rst) begin
      canvas_width  <= CFG_W'(640);
      canvas_height <= CFG_W'(480);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CANVAS_WIDTH:  canvas_width  <= cfg_data;
        CFG_CANVAS_HEIGHT: canvas_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // Clamp the canvas size to the largest supported side. A zero width or
  // height simply clips every pixel.
  always_comb begin
    if (32'(canvas_width) > MAX_CANVAS_SIDE) begin
      cw_eff = SIDE_W'(MAX_CANVAS_SIDE);
    end else begin
      cw_eff = SIDE_W'(canvas_width);
    end
    if (32'(canvas_height) > MAX_CANVAS_SIDE) begin
      ch_eff = SIDE_W'(MAX_CANVAS_SIDE);
    end else begin
      ch_eff = SIDE_W'(canvas_height);
    end
  end

  // The parser walks the header, the skip region and the padded rows, and
  // turns each visible pixel or status event into one request.
  bmp565_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .data_byte  (in_ch.data_byte),
    .first_byte (in_ch.first_byte),
    .canvas_w   (cw_eff),
    .canvas_h   (ch_eff),
    .q_full     (q_full),
    .push       (push),
    .cmd        (push_cmd)
  );

  // The queue lets the parser keep taking bytes while the output is stalled.
  bmp565_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (pop_cmd),
    .not_empty (q_valid)
  );

  // The write-out pipeline forms row * canvas_width + column.
  bmp565_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_pop         (q_pop),
    .q_data        (pop_cmd),
    .canvas_w      (cw_eff),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .status        (out_status),
    .pixel_address (out_ch.pixel_address),
    .pixel_color   (out_ch.pixel_color)
  );

  assign out_ch.status = out_status;

endmodule

`default_nettype wire
